// File: hdl/tkm_pkg.sv
// Shared types, codes and defaults for the trie keyword masker.
package tkm_pkg;

    localparam int NODES_DEF       = 1024;
    localparam int MAX_KEY_LEN_DEF = 32;
    localparam logic [7:0] MASK_RESET = 8'd42;

    localparam logic [1:0] OP_CLEAR   = 2'd0;
    localparam logic [1:0] OP_KEYWORD = 2'd1;
    localparam logic [1:0] OP_TEXT    = 2'd2;

    localparam logic [1:0] ST_TEXT     = 2'd0;
    localparam logic [1:0] ST_STORED   = 2'd1;
    localparam logic [1:0] ST_FULL     = 2'd2;
    localparam logic [1:0] ST_TOO_LONG = 2'd3;

    typedef struct packed {
        logic [1:0] operation;
        logic [7:0] in_byte;
        logic       in_last;
    } in_word_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       out_last;
        logic [1:0] status;
    } out_word_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_KUPD,
        S_KFIN,
        S_TCHECK,
        S_TWALK,
        S_SRCH,
        S_SCMP,
        S_TSTEP,
        S_TEMIT
    } fsm_state_t;

endpackage

// File: hdl/tkm_trie_mem.sv
// Trie edge and leaf storage: one write port, one registered read port.
module tkm_trie_mem #(
    parameter int NODES = tkm_pkg::NODES_DEF
) (
    input  logic                           clk,
    input  logic [$clog2(NODES)-1:0]       wr_addr,
    input  logic                           edge_we,
    input  logic [8+$clog2(NODES)-1:0]     edge_wdata,
    input  logic                           leaf_we,
    input  logic                           leaf_wdata,
    input  logic [$clog2(NODES)-1:0]       rd_addr,
    output logic [8+$clog2(NODES)-1:0]     rd_edge,
    output logic                           rd_leaf
);
    localparam int NB = $clog2(NODES);

    logic [8+NB-1:0] edge_mem [NODES];
    logic            leaf_mem [NODES];

    // Write edge and leaf mark
    always_ff @(posedge clk)
    begin
        if (edge_we)
        begin
            edge_mem[wr_addr] <= edge_wdata;
        end
        if (leaf_we)
        begin
            leaf_mem[wr_addr] <= leaf_wdata;
        end
    end

    // Read one node per cycle
    always_ff @(posedge clk)
    begin
        rd_edge <= edge_mem[rd_addr];
        rd_leaf <= leaf_mem[rd_addr];
    end

endmodule

// File: hdl/trie_keyword_masker_top.sv
// Top level of the trie keyword masker: sequencer, text window and output register.
// A child lookup scans the node table, visiting SRCH and SCMP for each stored node; a
// keyword byte needs one such lookup, a text byte up to MAX_KEY_LEN such lookups per
// start position before its words are emitted. One item in flight at a time.
// The node table scan through the single memory read port sets the rate.
// Reset (rst_n low, asynchronous): empty dictionary, empty window, mask byte 42.
module trie_keyword_masker_top #(
    parameter int NODES       = tkm_pkg::NODES_DEF,
    parameter int MAX_KEY_LEN = tkm_pkg::MAX_KEY_LEN_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  tkm_pkg::in_word_t   in_data,
    output logic                out_valid,
    input  logic                out_ready,
    output tkm_pkg::out_word_t  out_data,
    input  logic                cfg_we,
    input  logic [7:0]          cfg_data
);
    localparam int NB  = $clog2(NODES);
    localparam int CW  = NB + 1;
    localparam int WB  = $clog2(MAX_KEY_LEN);
    localparam int WIN = 1 << WB;
    localparam int FW  = $clog2(MAX_KEY_LEN + 1);
    localparam logic [CW-1:0] NODES_C = CW'(NODES);
    localparam logic [FW-1:0] MAX_C   = FW'(MAX_KEY_LEN);

    tkm_pkg::fsm_state_t state_reg, state_next;

    logic [7:0]      mask_reg;
    logic [CW-1:0]   node_count_reg, node_count_next;
    logic [NB-1:0]   cursor_reg, cursor_next;
    logic [FW-1:0]   depth_reg, depth_next;
    logic [1:0]      err_reg, err_next;
    logic [WB-1:0]   head_reg, head_next;
    logic [FW-1:0]   fill_reg, fill_next;
    logic            last_reg, last_next;
    logic            kmode_reg, kmode_next;
    logic [7:0]      key_reg, key_next;
    logic [NB-1:0]   parent_reg, parent_next;
    logic [CW-1:0]   k_reg, k_next;
    logic            found_reg, found_next;
    logic            hit_reg, hit_next;
    logic [NB-1:0]   node_reg, node_next;
    logic [FW-1:0]   d_reg, d_next;
    logic [FW-1:0]   best_reg, best_next;
    logic            out_valid_reg, out_valid_next;
    tkm_pkg::out_word_t out_reg, out_next;

    logic [7:0]      win_reg [WIN];
    logic            win_we;
    logic [WB-1:0]   win_wa;
    logic [WB-1:0]   win_ra;
    logic [7:0]      win_rd;

    logic [NB-1:0]   wr_addr, rd_addr;
    logic            edge_we, leaf_we, leaf_wdata;
    logic [8+NB-1:0] rd_edge;
    logic            rd_leaf;
    logic            slot_free;
    logic            accept;

    tkm_trie_mem #(.NODES(NODES)) u_mem (
        .clk        (clk),
        .wr_addr    (wr_addr),
        .edge_we    (edge_we),
        .edge_wdata ({key_reg, cursor_reg}),
        .leaf_we    (leaf_we),
        .leaf_wdata (leaf_wdata),
        .rd_addr    (rd_addr),
        .rd_edge    (rd_edge),
        .rd_leaf    (rd_leaf)
    );

    assign in_ready  = (state_reg == tkm_pkg::S_IDLE);
    assign accept    = in_valid && in_ready;
    assign slot_free = !out_valid_reg || out_ready;
    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;
    assign win_rd    = win_reg[win_ra];

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            tkm_pkg::S_IDLE:
            begin
                if (accept)
                begin
                    if (in_data.operation == tkm_pkg::OP_KEYWORD)
                    begin
                        if (err_reg != 2'd0 || depth_reg >= MAX_C)
                            state_next = tkm_pkg::S_KFIN;
                        else
                            state_next = tkm_pkg::S_SRCH;
                    end
                    else if (in_data.operation == tkm_pkg::OP_TEXT)
                        state_next = tkm_pkg::S_TCHECK;
                end
            end
            tkm_pkg::S_KUPD:   state_next = tkm_pkg::S_KFIN;
            tkm_pkg::S_KFIN:
            begin
                if (!last_reg || slot_free)
                    state_next = tkm_pkg::S_IDLE;
            end
            tkm_pkg::S_TCHECK:
            begin
                if (fill_reg != '0 && (fill_reg >= MAX_C || last_reg))
                    state_next = tkm_pkg::S_TWALK;
                else
                    state_next = tkm_pkg::S_IDLE;
            end
            tkm_pkg::S_TWALK:
            begin
                if (d_reg >= fill_reg)
                    state_next = tkm_pkg::S_TEMIT;
                else
                    state_next = tkm_pkg::S_SRCH;
            end
            tkm_pkg::S_SRCH:
            begin
                if (k_reg >= node_count_reg)
                    state_next = kmode_reg ? tkm_pkg::S_KUPD : tkm_pkg::S_TSTEP;
                else
                    state_next = tkm_pkg::S_SCMP;
            end
            tkm_pkg::S_SCMP:
            begin
                if (rd_edge == {key_reg, parent_reg})
                    state_next = kmode_reg ? tkm_pkg::S_KUPD : tkm_pkg::S_TSTEP;
                else
                    state_next = tkm_pkg::S_SRCH;
            end
            tkm_pkg::S_TSTEP:
            begin
                if (found_reg)
                    state_next = tkm_pkg::S_TWALK;
                else
                    state_next = tkm_pkg::S_TEMIT;
            end
            tkm_pkg::S_TEMIT:
            begin
                if (slot_free && best_reg <= FW'(1))
                    state_next = tkm_pkg::S_TCHECK;
            end
            default: state_next = tkm_pkg::S_IDLE;
        endcase
    end

    // Datapath and outputs
    always_comb
    begin
        node_count_next = node_count_reg;
        cursor_next     = cursor_reg;
        depth_next      = depth_reg;
        err_next        = err_reg;
        head_next       = head_reg;
        fill_next       = fill_reg;
        last_next       = last_reg;
        kmode_next      = kmode_reg;
        key_next        = key_reg;
        parent_next     = parent_reg;
        k_next          = k_reg;
        found_next      = found_reg;
        hit_next        = hit_reg;
        node_next       = node_reg;
        d_next          = d_reg;
        best_next       = best_reg;
        out_next        = out_reg;
        out_valid_next  = out_valid_reg && !out_ready;
        win_we          = 1'b0;
        win_wa          = head_reg + WB'(fill_reg);
        win_ra          = head_reg;
        wr_addr         = cursor_reg;
        rd_addr         = k_reg[NB-1:0];
        edge_we         = 1'b0;
        leaf_we         = 1'b0;
        leaf_wdata      = 1'b0;

        unique case (state_reg)
            tkm_pkg::S_IDLE:
            begin
                if (accept)
                begin
                    last_next = in_data.in_last;
                    key_next  = in_data.in_byte;
                    if (in_data.operation == tkm_pkg::OP_CLEAR)
                    begin
                        node_count_next = CW'(1);
                        cursor_next     = '0;
                        depth_next      = '0;
                        err_next        = 2'd0;
                    end
                    else if (in_data.operation == tkm_pkg::OP_KEYWORD)
                    begin
                        kmode_next  = 1'b1;
                        parent_next = cursor_reg;
                        k_next      = CW'(1);
                        found_next  = 1'b0;
                        if (err_reg == 2'd0 && depth_reg >= MAX_C)
                            err_next = tkm_pkg::ST_TOO_LONG;
                    end
                    else if (in_data.operation == tkm_pkg::OP_TEXT)
                    begin
                        kmode_next = 1'b0;
                        if (fill_reg < MAX_C)
                        begin
                            win_we    = 1'b1;
                            fill_next = fill_reg + FW'(1);
                        end
                    end
                end
            end
            tkm_pkg::S_KUPD:
            begin
                // follow existing edge or grow a new node
                if (found_reg)
                begin
                    cursor_next = k_reg[NB-1:0];
                    depth_next  = depth_reg + FW'(1);
                end
                else if (node_count_reg >= NODES_C)
                    err_next = tkm_pkg::ST_FULL;
                else
                begin
                    wr_addr         = node_count_reg[NB-1:0];
                    edge_we         = 1'b1;
                    leaf_we         = 1'b1;
                    leaf_wdata      = 1'b0;
                    cursor_next     = node_count_reg[NB-1:0];
                    node_count_next = node_count_reg + CW'(1);
                    depth_next      = depth_reg + FW'(1);
                end
            end
            tkm_pkg::S_KFIN:
            begin
                if (last_reg && slot_free)
                begin
                    out_valid_next    = 1'b1;
                    out_next.out_byte = 8'd0;
                    out_next.out_last = 1'b0;
                    out_next.status   = (err_reg != 2'd0) ? err_reg : tkm_pkg::ST_STORED;
                    if (err_reg == 2'd0 && cursor_reg != '0)
                    begin
                        leaf_we    = 1'b1;
                        leaf_wdata = 1'b1;
                    end
                    cursor_next = '0;
                    depth_next  = '0;
                    err_next    = 2'd0;
                end
            end
            tkm_pkg::S_TCHECK:
            begin
                node_next = '0;
                d_next    = '0;
                best_next = '0;
            end
            tkm_pkg::S_TWALK:
            begin
                // look up the next window byte under the current node
                win_ra      = head_reg + WB'(d_reg);
                key_next    = win_rd;
                parent_next = node_reg;
                k_next      = CW'(1);
                found_next  = 1'b0;
            end
            tkm_pkg::S_SRCH:
            begin
                rd_addr = k_reg[NB-1:0];
            end
            tkm_pkg::S_SCMP:
            begin
                if (rd_edge == {key_reg, parent_reg})
                begin
                    found_next = 1'b1;
                    hit_next   = rd_leaf;
                end
                else
                    k_next = k_reg + CW'(1);
            end
            tkm_pkg::S_TSTEP:
            begin
                if (found_reg)
                begin
                    node_next = k_reg[NB-1:0];
                    d_next    = d_reg + FW'(1);
                    if (hit_reg)
                        best_next = d_reg + FW'(1);
                end
            end
            tkm_pkg::S_TEMIT:
            begin
                // emit one word and drop it from the window
                if (slot_free)
                begin
                    out_valid_next    = 1'b1;
                    out_next.out_byte = (best_reg == '0) ? win_rd : mask_reg;
                    out_next.out_last = last_reg && (fill_reg == FW'(1));
                    out_next.status   = tkm_pkg::ST_TEXT;
                    head_next         = head_reg + WB'(1);
                    fill_next         = fill_reg - FW'(1);
                    if (best_reg != '0)
                        best_next = best_reg - FW'(1);
                end
            end
            default: ;
        endcase
    end

    // Hold text window bytes
    always_ff @(posedge clk)
    begin
        if (win_we)
        begin
            win_reg[win_wa] <= key_next;
        end
    end

    // Hold payload registers
    always_ff @(posedge clk)
    begin
        key_reg    <= key_next;
        parent_reg <= parent_next;
        k_reg      <= k_next;
        hit_reg    <= hit_next;
        node_reg   <= node_next;
        d_reg      <= d_next;
        best_reg   <= best_next;
        out_reg    <= out_next;
    end

    // Advance control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= tkm_pkg::S_IDLE;
            mask_reg       <= tkm_pkg::MASK_RESET;
            node_count_reg <= CW'(1);
            cursor_reg     <= '0;
            depth_reg      <= '0;
            err_reg        <= 2'd0;
            head_reg       <= '0;
            fill_reg       <= '0;
            last_reg       <= 1'b0;
            kmode_reg      <= 1'b0;
            found_reg      <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            if (cfg_we)
            begin
                mask_reg <= cfg_data;
            end
            node_count_reg <= node_count_next;
            cursor_reg     <= cursor_next;
            depth_reg      <= depth_next;
            err_reg        <= err_next;
            head_reg       <= head_next;
            fill_reg       <= fill_next;
            last_reg       <= last_next;
            kmode_reg      <= kmode_next;
            found_reg      <= found_next;
            out_valid_reg  <= out_valid_next;
        end
    end

endmodule
